[hdl/kmd_pkg.sv]
// shared types, constants and helpers for the keypad matrix debouncer
`default_nettype none

package kmd_pkg;

    // keypad geometry
    localparam int ROWS      = 4;
    localparam int COLS      = 3;
    localparam int MAX_KEYS  = ROWS * COLS;

    // default number of scanned keys
    localparam int KEY_COUNT_DEF = MAX_KEYS;

    // field widths
    localparam int CNT_W  = 8;
    localparam int KEY_W  = 4;
    localparam int COL_W  = 3;

    // reset value of the threshold register
    localparam logic [CNT_W-1:0] NOISE_RESET = 8'd3;

    // sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // result of one counter update
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             fire;
    } t_upd;

    // active-low columns to a one-hot winner, left over center over right
    function automatic logic [COL_W-1:0] row_onehot(input logic [COL_W-1:0] cols);
        logic [COL_W-1:0] win;
        win[0] = ~cols[0];
        win[1] =  cols[0] & ~cols[1];
        win[2] =  cols[0] &  cols[1] & ~cols[2];
        return win;
    endfunction

endpackage

`default_nettype wire

[hdl/kmd_cnt_unit.sv]
// shared counter update and threshold compare for one key per cycle
`default_nettype none

module kmd_cnt_unit (
    input  wire logic [kmd_pkg::CNT_W-1:0] i_count,
    input  wire logic                      i_pressed,
    input  wire logic [kmd_pkg::CNT_W-1:0] i_press_limit,
    output kmd_pkg::t_upd                  o_upd
);

    logic [kmd_pkg::CNT_W-1:0] w_thresh;
    logic [kmd_pkg::CNT_W-1:0] w_next;

    // clamp threshold to 1..254 so the saturated count still fits
    always_comb begin
        if (i_press_limit == '0) begin
            w_thresh = kmd_pkg::CNT_W'(1);
        end else if (i_press_limit == '1) begin
            w_thresh = kmd_pkg::CNT_W'(254);
        end else begin
            w_thresh = i_press_limit;
        end
    end

    // count up while pressed, saturate at threshold plus one, clear on release
    always_comb begin
        if (!i_pressed) begin
            w_next = '0;
        end else if (i_count <= w_thresh) begin
            w_next = i_count + kmd_pkg::CNT_W'(1);
        end else begin
            w_next = i_count;
        end
    end

    // new count and fire flag
    assign o_upd = {w_next, (w_next == w_thresh)};

endmodule

`default_nettype wire

[hdl/kmd_emit.sv]
// event emitter: walks the fired-key mask in key order into an output register
`default_nettype none

module kmd_emit #(
    parameter int KEY_COUNT = kmd_pkg::KEY_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [KEY_COUNT-1:0]      i_mask,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [kmd_pkg::KEY_W-1:0]      o_key_number,
    output logic                           o_last_event,
    output logic                           o_busy
);

    localparam int IW = $clog2(KEY_COUNT);

    logic [KEY_COUNT-1:0]      r_mask;
    logic                      r_valid;
    logic [kmd_pkg::KEY_W-1:0] r_key;
    logic                      r_last;

    logic [KEY_COUNT-1:0] w_low;
    logic [KEY_COUNT-1:0] w_rest;
    logic [IW-1:0]        w_idx;
    logic                 w_adv;

    // lowest pending key and what is left after it
    assign w_low  = r_mask & (~r_mask + KEY_COUNT'(1));
    assign w_rest = r_mask & ~w_low;

    // one-hot to index
    always_comb begin
        w_idx = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (w_low[k]) begin
                w_idx = w_idx | IW'(k);
            end
        end
    end

    // move a beat into the output register when it is free or being taken
    assign w_adv = (r_mask != '0) && (!r_valid || i_out_ready);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_mask;
            end else if (w_adv) begin
                r_mask <= w_rest;
            end
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_key  <= kmd_pkg::KEY_W'(w_idx) + kmd_pkg::KEY_W'(1);
            r_last <= (w_rest == '0);
        end
    end

    assign o_out_valid  = r_valid;
    assign o_key_number = r_key;
    assign o_last_event = r_last;
    assign o_busy       = (r_mask != '0);

endmodule

`default_nettype wire

[hdl/keypad_matrix_debounce.sv]
// top level: scan-tick debouncer for a 4 by 3 keypad matrix
`default_nettype none

// One scan tick (all four rows of active-low column readings) is taken per input
// beat. The press counters of the KEY_COUNT keys are then updated one key per
// cycle through a single shared increment and compare unit. Keys whose count
// reaches the threshold are queued and sent out in key order, one result beat
// per cycle while the consumer is ready, with the last beat of the tick flagged.
// The next tick is accepted once the update pass is done and every queued event
// has moved to the output register. Counters reset to zero at once; there is no
// clearing pass. The press threshold is clamped to 1..254 and is meant to be
// written only between ticks.
module keypad_matrix_debounce #(
    parameter int KEY_COUNT = kmd_pkg::KEY_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [kmd_pkg::CNT_W-1:0] i_cfg_wdata,
    // scan tick input
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [kmd_pkg::COL_W-1:0] i_row_one_columns,
    input  wire logic [kmd_pkg::COL_W-1:0] i_row_two_columns,
    input  wire logic [kmd_pkg::COL_W-1:0] i_row_three_columns,
    input  wire logic [kmd_pkg::COL_W-1:0] i_row_four_columns,
    // key events
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [kmd_pkg::KEY_W-1:0]      o_key_number,
    output logic                           o_last_event
);

    localparam int IW = $clog2(KEY_COUNT);

    kmd_pkg::t_state           r_state;
    kmd_pkg::t_state           n_state;
    logic [IW-1:0]             r_idx;
    logic [KEY_COUNT-1:0]      r_pressed;
    logic [KEY_COUNT-1:0]      r_fire;
    logic [kmd_pkg::CNT_W-1:0] r_press_limit;
    logic [kmd_pkg::CNT_W-1:0] r_counters [KEY_COUNT];

    logic [kmd_pkg::MAX_KEYS-1:0] w_press_all;
    logic [KEY_COUNT-1:0]         w_fire_final;
    logic                         w_in_acc;
    logic                         w_last_key;
    logic                         w_load;
    logic                         w_emit_busy;
    kmd_pkg::t_upd                w_upd;

    // row winners, key 0 is row one left
    assign w_press_all = {kmd_pkg::row_onehot(i_row_four_columns),
                          kmd_pkg::row_onehot(i_row_three_columns),
                          kmd_pkg::row_onehot(i_row_two_columns),
                          kmd_pkg::row_onehot(i_row_one_columns)};

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last_key = (r_idx == IW'(KEY_COUNT - 1));

    // shared update unit
    kmd_cnt_unit u_cnt (
        .i_count       (r_counters[r_idx]),
        .i_pressed     (r_pressed[r_idx]),
        .i_press_limit (r_press_limit),
        .o_upd         (w_upd)
    );

    // fire mask including the key being updated now
    assign w_fire_final = r_fire | (KEY_COUNT'(w_upd.fire) << r_idx);

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            kmd_pkg::ST_IDLE: begin
                o_in_ready = !w_emit_busy;
                if (i_in_valid && !w_emit_busy) begin
                    n_state = kmd_pkg::ST_UPDATE;
                end
            end
            kmd_pkg::ST_UPDATE: begin
                if (w_last_key) begin
                    w_load  = 1'b1;
                    n_state = kmd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kmd_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_limit <= kmd_pkg::NOISE_RESET;
        end else if (i_cfg_we) begin
            r_press_limit <= i_cfg_wdata;
        end
    end

    // key walk index, latched tick and fire bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_fire <= '0;
        end else if (w_in_acc) begin
            r_idx  <= '0;
            r_fire <= '0;
        end else if (r_state == kmd_pkg::ST_UPDATE) begin
            r_idx  <= w_last_key ? '0 : r_idx + IW'(1);
            r_fire <= w_fire_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pressed <= w_press_all[KEY_COUNT-1:0];
        end
    end

    // press counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_counters[k] <= '0;
            end
        end else if (r_state == kmd_pkg::ST_UPDATE) begin
            r_counters[r_idx] <= w_upd.count;
        end
    end

    // event output stage
    kmd_emit #(
        .KEY_COUNT (KEY_COUNT)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_mask       (w_fire_final),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_key_number (o_key_number),
        .o_last_event (o_last_event),
        .o_busy       (w_emit_busy)
    );

    // every accepted tick is back in idle once its update pass is over
    a_pass_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##(KEY_COUNT + 1) (r_state == kmd_pkg::ST_IDLE))
        else $error("update pass length wrong");

    // the key walk stays inside the counter array
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmd_pkg::ST_UPDATE) |-> (r_idx <= IW'(KEY_COUNT - 1)))
        else $error("key index out of range");

    // only a pressed key can fire
    a_fire_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmd_pkg::ST_UPDATE && w_upd.fire) |-> r_pressed[r_idx])
        else $error("released key fired");

    // emitted key numbers are real keys
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_number >= kmd_pkg::KEY_W'(1)
                         && o_key_number <= kmd_pkg::KEY_W'(KEY_COUNT)))
        else $error("key number out of range");

endmodule

`default_nettype wire

[tb/sv/tb_keypad_matrix_debounce.sv]
// testbench for the keypad matrix debouncer: scoreboard class, drivers and checks
`timescale 1ns / 100ps

typedef struct packed {
    logic [3:0] key;
    logic       last;
} t_key_event;

// tracks the press counters and the key events each scan tick should raise
class key_event_board;
    bit [7:0]   press_limit;
    bit [7:0]   press_cnt [12];
    t_key_event due_events [$];
    int         key_count;
    int         mismatch_cnt;

    function new(int keys);
        key_count    = keys;
        press_limit  = kmd_pkg::NOISE_RESET;
        mismatch_cnt = 0;
        foreach (press_cnt[i]) press_cnt[i] = 8'd0;
    endfunction

    function void set_noise(bit [7:0] value);
        press_limit = value;
    endfunction

    // count a problem, print only the first few
    function void flag(string msg);
        if (mismatch_cnt < 10) $display("[%0t] %s", $time, msg);
        mismatch_cnt++;
    endfunction

    // one accepted scan tick; row r sits at bits 3r+2..3r, active low
    function void note_tick(bit [11:0] tick);
        bit [11:0]  hit;
        int         limit;
        int         win;
        int         fired [$];
        t_key_event ev;
        // zero acts as one, 255 as 254
        limit = (press_limit == 8'd0) ? 1 : (press_limit == 8'd255) ? 254 : press_limit;
        hit = '0;
        // left beats center beats right within a row
        for (int r = 0; r < 4; r++) begin
            win = 3;
            for (int c = 2; c >= 0; c--) begin
                if (!tick[3*r + c]) win = c;
            end
            if (win < 3) hit[3*r + win] = 1'b1;
        end
        // counters rise while pressed, saturate at limit+1, clear on release
        for (int i = 0; i < 12; i++) begin
            if (hit[i] && i < key_count) begin
                if (press_cnt[i] <= limit) press_cnt[i] = press_cnt[i] + 8'd1;
            end else begin
                press_cnt[i] = 8'd0;
            end
            if (press_cnt[i] == limit) fired.push_back(i + 1);
        end
        foreach (fired[j]) begin
            ev.key  = 4'(fired[j]);
            ev.last = (j == fired.size() - 1);
            due_events.push_back(ev);
        end
    endfunction

    // one result beat against the oldest due event
    function void check_event(logic [3:0] key, logic last);
        t_key_event want;
        if (due_events.size() == 0) begin
            flag($sformatf("unexpected event: key %0d last %0b", key, last));
            return;
        end
        want = due_events.pop_front();
        if (key !== want.key)
            flag($sformatf("key_number: expected %0d, got %0d", want.key, key));
        if (last !== want.last)
            flag($sformatf("last_event on key %0d: expected %0b, got %0b",
                           want.key, want.last, last));
    endfunction

    function int outstanding();
        return due_events.size();
    endfunction

    // events never delivered count as failures
    function void close_out();
        if (due_events.size() != 0)
            flag($sformatf("%0d events never arrived", due_events.size()));
        mismatch_cnt += (due_events.size() > 1) ? due_events.size() - 1 : 0;
    endfunction
endclass

module tb_keypad_matrix_debounce;

    localparam int KEYS          = kmd_pkg::KEY_COUNT_DEF;
    localparam int SETTLE_CYCLES = KEYS + 12;
    localparam int PHASES        = 7;

    logic                      i_clk               = 1'b0;
    logic                      i_rst_n             = 1'b0;
    logic                      i_cfg_we            = 1'b0;
    logic [kmd_pkg::CNT_W-1:0] i_cfg_wdata         = '0;
    logic                      i_in_valid          = 1'b0;
    logic [kmd_pkg::COL_W-1:0] i_row_one_columns   = 3'd7;
    logic [kmd_pkg::COL_W-1:0] i_row_two_columns   = 3'd7;
    logic [kmd_pkg::COL_W-1:0] i_row_three_columns = 3'd7;
    logic [kmd_pkg::COL_W-1:0] i_row_four_columns  = 3'd7;
    logic                      i_out_ready         = 1'b0;
    wire                       o_in_ready;
    wire                       o_out_valid;
    wire  [kmd_pkg::KEY_W-1:0] o_key_number;
    wire                       o_last_event;

    keypad_matrix_debounce #(.KEY_COUNT(KEYS)) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_row_one_columns   (i_row_one_columns),
        .i_row_two_columns   (i_row_two_columns),
        .i_row_three_columns (i_row_three_columns),
        .i_row_four_columns  (i_row_four_columns),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_key_number        (o_key_number),
        .o_last_event        (o_last_event)
    );

    always #10 i_clk = ~i_clk;

    key_event_board board;

    // per-phase threshold, length and how sticky the rows are
    bit [7:0] phase_noise [PHASES] = '{8'd1, 8'd2, 8'd4, 8'd255, 8'd254, 8'd7, 8'd3};
    int       phase_len   [PHASES] = '{30, 40, 40, 262, 20, 35, 35};
    int       phase_hold  [PHASES] = '{60, 75, 85, 100, 85, 92, 80};

    int       burst_left = 0;
    bit [2:0] held_cols [4];
    int       hold_pct  [4];

    // receiver: always ready, a rotating random mask, or a mostly stalled window
    int        rx_mode     = 0;
    bit [15:0] rdy_pattern = 16'hA5C3;
    bit [3:0]  rx_phase    = 4'd0;

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 4'd1;
        if (rx_phase == 4'd15)
            rdy_pattern <= 16'($urandom) | 16'h0001;
        else
            rdy_pattern <= {rdy_pattern[14:0], rdy_pattern[15]};
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= rdy_pattern[0];
            default: i_out_ready <= (rx_phase < 4'd4);
        endcase
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_event(o_key_number, o_last_event);
    end

    // present one scan tick, with burst gaps, and hold it until accepted
    task automatic send_tick(bit [11:0] tick);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_row_one_columns   = tick[2:0];
        i_row_two_columns   = tick[5:3];
        i_row_three_columns = tick[8:6];
        i_row_four_columns  = tick[11:9];
        i_in_valid          = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_tick(tick);
    endtask

    // stop sending and let every due event drain, then let the block settle
    task automatic go_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_noise(bit [7:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.set_noise(value);
    endtask

    // sticky rows: each keeps its columns unless it rolls a change
    function automatic bit [11:0] next_tick();
        for (int r = 0; r < 4; r++) begin
            if ($urandom_range(99) >= hold_pct[r]) held_cols[r] = 3'($urandom_range(7));
        end
        return {held_cols[3], held_cols[2], held_cols[1], held_cols[0]};
    endfunction

    initial begin
        board = new(KEYS);
        foreach (held_cols[r]) held_cols[r] = 3'd7;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset threshold of 3: left column, center, right, multi-press priority
        send_tick({3'd7, 3'd7, 3'd7, 3'd7});
        repeat (4) send_tick({3'd0, 3'd0, 3'd0, 3'd0});
        repeat (3) send_tick({3'd7, 3'd6, 3'd3, 3'd5});
        send_tick({3'd7, 3'd7, 3'd7, 3'd7});
        repeat (3) send_tick({3'd0, 3'd4, 3'd2, 3'd1});
        // a press broken by one released tick starts counting over
        send_tick({3'd7, 3'd1, 3'd7, 3'd1});
        send_tick({3'd7, 3'd1, 3'd7, 3'd7});
        send_tick({3'd7, 3'd1, 3'd7, 3'd1});
        send_tick({3'd7, 3'd7, 3'd7, 3'd7});

        // zero threshold behaves as one: each new press fires at once
        go_quiet();
        write_noise(8'd0);
        send_tick({3'd7, 3'd3, 3'd5, 3'd6});
        send_tick({3'd7, 3'd3, 3'd5, 3'd6});
        send_tick({3'd0, 3'd7, 3'd7, 3'd7});

        // random phases over a spread of thresholds and receiver behaviors
        for (int p = 0; p < PHASES; p++) begin
            go_quiet();
            write_noise(phase_noise[p]);
            rx_mode = (p == 0) ? 0 : int'($urandom_range(2));
            foreach (hold_pct[r]) hold_pct[r] = phase_hold[p];
            if (phase_noise[p] == 8'd255) begin
                // long holds on three rows to reach the clamped threshold
                for (int r = 0; r < 3; r++) held_cols[r] = 3'($urandom_range(6));
                hold_pct[3] = 50;
            end
            for (int k = 0; k < phase_len[p]; k++) begin
                if (p == 2 && k == phase_len[p] / 2) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (board.outstanding() != 0) @(posedge i_clk);
                end
                send_tick(next_tick());
            end
        end

        go_quiet();
        board.close_out();
        if (board.mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
hdl/kmd_pkg.sv
hdl/kmd_cnt_unit.sv
hdl/kmd_emit.sv
hdl/keypad_matrix_debounce.sv
tb/sv/tb_keypad_matrix_debounce.sv
